@@ design/utf8_boundary_truncating_copy_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-8 truncating copy: assertion macros
// Concurrent assertion wrappers. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_BOUNDARY_TRUNCATING_COPY_DEFINES_SVH
`define UTF8_BOUNDARY_TRUNCATING_COPY_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset
`define U8BTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included
`define U8BTC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define U8BTC_ASSERT(name, prop, msg)
`define U8BTC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ design/u8btc_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 truncating copy package
// Constants, types and byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package u8btc_pkg;

  // Capacity register
  localparam int unsigned CAP_W        = 9;
  localparam logic [CAP_W-1:0] CAP_RESET    = 9'd64;
  localparam logic [CAP_W-1:0] MAX_CAPACITY = 9'd256;
  localparam logic [CAP_W-1:0] MIN_CAPACITY = 9'd1;

  // APB map: one register, word aligned
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [0:0]  REG_CAPACITY = 1'b0;

  // Byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_CODE   = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;

  // Result group queue
  localparam int unsigned GRP_BYTES = 4;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  // Up to four output bytes produced by one input item
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [GRP_BYTES-1:0]      eoc;
    logic [1:0]                last_idx;
  } grp_t;

  // Outcome of taking a byte as the start of a sequence
  typedef struct packed {
    logic       stop_now;
    logic       emit;
    logic       hold;
    logic [2:0] len;
  } lead_dec_t;

  function automatic logic [2:0] seq_len(logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b < ASCII_LIMIT)                     len = 3'd1;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) len = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(logic [7:0] b);
    return (b & CONT_MASK) == CONT_CODE;
  endfunction

  // Clamp the programmed capacity into the supported range
  function automatic logic [CAP_W-1:0] eff_capacity(logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] c;
    c = cap;
    if (c < MIN_CAPACITY) c = MIN_CAPACITY;
    if (c > MAX_CAPACITY) c = MAX_CAPACITY;
    return c;
  endfunction

  // Decide what a lead byte does given the bytes written so far
  function automatic lead_dec_t lead_decide(logic [CAP_W-1:0] w, logic [CAP_W-1:0] cap,
                                            logic stopped, logic [7:0] b);
    lead_dec_t       d;
    logic [CAP_W:0]  need;
    d     = '0;
    d.len = seq_len(b);
    need  = {1'b0, w} + {{(CAP_W-2){1'b0}}, d.len};
    if (!stopped) begin
      if (need >= {1'b0, cap}) begin
        d.stop_now = 1'b1;
      end else if (d.len == 3'd1) begin
        d.emit = 1'b1;
      end else begin
        d.hold = 1'b1;
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/utf8_boundary_truncating_copy.sv @@
// ----------------------------------------------------------------------------
// UTF-8 truncating copy
// Copies a byte string into a destination of programmable capacity without
// splitting a multi-byte UTF-8 sequence, then appends the terminator.
// ----------------------------------------------------------------------------
// One input item is taken per clock while the result queue has room. Each item
// is resolved in the cycle it is accepted and yields zero to four result
// bytes, which are stored as one group in a four-entry queue and leave on the
// output channel one byte per clock while out_stall_i is low. Sustained rate is
// one item per cycle for items with at most one result while the output is not
// stalled; an item with several results takes one output transfer per result
// byte, and the input stalls only when all four queue entries hold groups not
// yet fully transferred. Capacity is register 0 at byte address 0 (reset 64,
// clamped into 1..256) and may be written only while the block is idle.
`default_nettype none

`include "utf8_boundary_truncating_copy_defines.svh"

module utf8_boundary_truncating_copy
  import u8btc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // APB configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  // Input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              cmd_i,
  input  wire logic [7:0]        data_byte_i,
  // Output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [7:0]        out_byte_o,
  output logic                   end_of_copy_o
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // String state
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0] written_q, written_d;
  logic [7:0]       lead_q, lead_d;
  logic [1:0][7:0]  held_q, held_d;
  logic [1:0]       held_cnt_q, held_cnt_d;
  logic [2:0]       seq_q, seq_d;
  logic             stopped_q, stopped_d;

  // Queue control
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [1:0]        rd_idx_q;
  grp_t              q_mem [QDEPTH];
  grp_t              head;

  logic in_xfer, out_xfer, push, pop;

  assign in_stall_o = (count_q == QCNT_W'(QDEPTH));
  assign in_xfer    = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Per-item resolution
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0]           cap_eff;
  logic [GRP_BYTES-1:0][7:0]  slot_byte;
  logic [GRP_BYTES-1:0]       slot_eoc;
  logic [2:0]                 n_res;
  lead_dec_t                  dec_r0, dec_r1, dec_b;
  logic [CAP_W-1:0]           w0, w1;
  logic                       s0, s1;

  assign cap_eff = eff_capacity(cap_q);

  always_comb begin
    written_d  = written_q;
    lead_d     = lead_q;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    seq_d      = seq_q;
    stopped_d  = stopped_q;
    slot_byte  = '0;
    slot_eoc   = '0;
    n_res      = 3'd0;
    w0         = written_q;
    s0         = stopped_q;
    w1         = written_q;
    s1         = stopped_q;
    dec_r0     = '0;
    dec_r1     = '0;
    dec_b      = '0;

    if (!cmd_i && (seq_q == 3'd0)) begin
      // Nothing pending: the byte starts a sequence
      dec_b = lead_decide(written_q, cap_eff, stopped_q, data_byte_i);
      if (dec_b.stop_now) stopped_d = 1'b1;
      if (dec_b.emit) begin
        slot_byte[0] = data_byte_i;
        n_res        = 3'd1;
        written_d    = written_q + 1'b1;
      end
      if (dec_b.hold) begin
        lead_d     = data_byte_i;
        seq_d      = dec_b.len;
        held_cnt_d = 2'd0;
      end
    end else if (!cmd_i && is_cont(data_byte_i)) begin
      // Continuation of the pending sequence
      if (({1'b0, held_cnt_q} + 3'd2) >= seq_q) begin
        slot_byte[n_res[1:0]] = lead_q;
        n_res = n_res + 3'd1;
        for (int i = 0; i < 2; i++) begin
          if (2'(i) < held_cnt_q) begin
            slot_byte[n_res[1:0]] = held_q[i];
            n_res = n_res + 3'd1;
          end
        end
        slot_byte[n_res[1:0]] = data_byte_i;
        n_res      = n_res + 3'd1;
        written_d  = written_q + {{(CAP_W-3){1'b0}}, seq_q};
        lead_d     = '0;
        held_d     = '0;
        held_cnt_d = 2'd0;
        seq_d      = 3'd0;
      end else begin
        held_d[held_cnt_q[0]] = data_byte_i;
        held_cnt_d            = held_cnt_q + 2'd1;
      end
    end else begin
      // Breaking byte or end item: drop the lead, replay held bytes singly
      lead_d     = '0;
      held_d     = '0;
      held_cnt_d = 2'd0;
      seq_d      = 3'd0;

      if (held_cnt_q > 2'd0) begin
        dec_r0 = lead_decide(written_q, cap_eff, stopped_q, held_q[0]);
        if (dec_r0.stop_now) s0 = 1'b1;
        if (dec_r0.emit) begin
          slot_byte[n_res[1:0]] = held_q[0];
          n_res = n_res + 3'd1;
          w0    = written_q + 1'b1;
        end
      end
      w1 = w0;
      s1 = s0;
      if (held_cnt_q > 2'd1) begin
        dec_r1 = lead_decide(w0, cap_eff, s0, held_q[1]);
        if (dec_r1.stop_now) s1 = 1'b1;
        if (dec_r1.emit) begin
          slot_byte[n_res[1:0]] = held_q[1];
          n_res = n_res + 3'd1;
          w1    = w0 + 1'b1;
        end
      end
      written_d = w1;
      stopped_d = s1;

      if (!cmd_i) begin
        dec_b = lead_decide(w1, cap_eff, s1, data_byte_i);
        if (dec_b.stop_now) stopped_d = 1'b1;
        if (dec_b.emit) begin
          slot_byte[n_res[1:0]] = data_byte_i;
          n_res     = n_res + 3'd1;
          written_d = w1 + 1'b1;
        end
        if (dec_b.hold) begin
          lead_d = data_byte_i;
          seq_d  = dec_b.len;
        end
      end else begin
        // Terminator closes the string
        slot_byte[n_res[1:0]] = 8'h00;
        slot_eoc[n_res[1:0]]  = 1'b1;
        n_res     = n_res + 3'd1;
        written_d = '0;
        stopped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      lead_q     <= '0;
      held_q     <= '0;
      held_cnt_q <= 2'd0;
      seq_q      <= 3'd0;
      stopped_q  <= 1'b0;
    end else if (in_xfer) begin
      written_q  <= written_d;
      lead_q     <= lead_d;
      held_q     <= held_d;
      held_cnt_q <= held_cnt_d;
      seq_q      <= seq_d;
      stopped_q  <= stopped_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result group queue
  // --------------------------------------------------------------------------
  grp_t grp_new;

  assign grp_new.bytes    = slot_byte;
  assign grp_new.eoc      = slot_eoc;
  assign grp_new.last_idx = 2'(n_res - 3'd1);

  assign push     = in_xfer && (n_res != 3'd0);
  assign head     = q_mem[rd_ptr_q];
  assign out_xfer = out_valid_o && !out_stall_i;
  assign pop      = out_xfer && (rd_idx_q == head.last_idx);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= grp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      rd_idx_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
      // Walk the bytes of the head group
      if (pop)           rd_idx_q <= 2'd0;
      else if (out_xfer) rd_idx_q <= rd_idx_q + 2'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Output channel
  // --------------------------------------------------------------------------
  assign out_valid_o   = (count_q != '0);
  assign out_byte_o    = head.bytes[rd_idx_q];
  assign end_of_copy_o = head.eoc[rd_idx_q];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `U8BTC_ASSERT_ALWAYS(a_queue_bound, !rst_ni || (count_q <= QCNT_W'(QDEPTH)),
                       "result queue overflow")
  `U8BTC_ASSERT(a_eoc_last,
                out_valid_o && end_of_copy_o |-> rd_idx_q == head.last_idx,
                "terminator not last of its group")
  `U8BTC_ASSERT(a_group_drains, out_xfer && !pop |=> out_valid_o, "group dropped mid transfer")
  `U8BTC_ASSERT(a_pending_live,
                seq_q != 3'd0 |-> !stopped_q && (({1'b0, held_cnt_q} + 3'd1) < seq_q),
                "bad pending sequence state")
  `U8BTC_ASSERT(a_written_bound, written_q < MAX_CAPACITY, "written count beyond capacity")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 truncating copy testbench
// Sends byte strings and end items through the input channel, programs the
// capacity over APB, and checks every output transfer against typed results
// or a cycle-free model of the copy kept in this file. A short table of
// directed items comes first, then random strings built mostly of well-formed
// sequences, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module testbench;
  import u8btc_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 430;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_PCT      = 27;
  localparam int HOLD_AFTER    = 120;
  localparam int HOLD_CYCLES   = 250;
  localparam int NO_WRITE      = -1;
  localparam int COMPUTED      = -1;
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_END     = 1'b1;
  localparam logic [APB_AW-1:0] CAP_ADDR = APB_AW'(4 * REG_CAPACITY);

  // One destination byte; term marks the terminator
  typedef struct packed {
    logic [7:0] value;
    logic       term;
  } dest_byte_t;

  // Directed row: optional capacity write, the item, and typed results
  typedef struct {
    int         cfg;
    logic       cmd;
    logic [7:0] data;
    int         nres;
    logic [7:0] res [4];
  } dir_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [APB_DW-1:0] pwdata        = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              cmd_i         = 1'b0;
  logic [7:0]        data_byte_i   = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [7:0]        out_byte_o;
  logic              end_of_copy_o;

  // Copy state mirrored from the block
  logic [CAP_W-1:0] cap_reg = CAP_RESET;
  int               written_n = 0;
  int               seq_n = 0;
  int               cont_n = 0;
  logic [7:0]       lead_q = 8'h00;
  logic [7:0]       cont_q [2] = '{8'h00, 8'h00};
  bit               stopped = 1'b0;
  dest_byte_t       dest_bytes_q [$];

  // Run bookkeeping
  int cycle_n = 0;
  int item_n = 0;
  int live_n = 0;
  int result_n = 0;
  int string_n = 0;
  int cap_write_n = 0;
  int mismatch_n = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  dir_row_t dir_tab [27] = '{
    // plain bytes and complete sequences at the default capacity
    '{NO_WRITE, CMD_BYTE, 8'h41, 1, '{8'h41, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hC3, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hA9, 2, '{8'hC3, 8'hA9, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hF0, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h9F, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h98, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h80, 4, '{8'hF0, 8'h9F, 8'h98, 8'h80}},
    // stray continuation, invalid lead and zero byte go out raw
    '{NO_WRITE, CMD_BYTE, 8'hBF, 1, '{8'hBF, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hFF, 1, '{8'hFF, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h00, 1, '{8'h00, 8'h00, 8'h00, 8'h00}},
    // broken three-byte sequence: lead lost, held byte replayed
    '{NO_WRITE, CMD_BYTE, 8'hE2, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h82, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h41, 2, '{8'h82, 8'h41, 8'h00, 8'h00}},
    // end item flushes a pending four-byte lead
    '{NO_WRITE, CMD_BYTE, 8'hF4, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'h8F, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_END,  8'hFF, 2, '{8'h8F, 8'h00, 8'h00, 8'h00}},
    // capacity one and zero: terminator only
    '{1,        CMD_BYTE, 8'h41, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_END,  8'h00, 1, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{0,        CMD_END,  8'h55, 1, '{8'h00, 8'h00, 8'h00, 8'h00}},
    // sequence that does not fit stops the copy
    '{3,        CMD_BYTE, 8'h41, 1, '{8'h41, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hC3, COMPUTED, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hA9, COMPUTED, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_END,  8'hAA, 1, '{8'h00, 8'h00, 8'h00, 8'h00}},
    // capacity change while a lead waits leaves the sequence alone
    '{511,      CMD_BYTE, 8'hE2, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{2,        CMD_BYTE, 8'h82, 0, '{8'h00, 8'h00, 8'h00, 8'h00}},
    '{NO_WRITE, CMD_BYTE, 8'hAC, 3, '{8'hE2, 8'h82, 8'hAC, 8'h00}},
    '{NO_WRITE, CMD_END,  8'h01, 1, '{8'h00, 8'h00, 8'h00, 8'h00}}
  };

  utf8_boundary_truncating_copy u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .end_of_copy_o (end_of_copy_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sequence length from the lead byte's top bits
  function automatic int utf8_len(logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 1;
    endcase
  endfunction

  function automatic int cap_limit();
    if (cap_reg == '0) return 1;
    if (cap_reg > MAX_CAPACITY) return int'(MAX_CAPACITY);
    return int'(cap_reg);
  endfunction

  function automatic void drop_sequence();
    lead_q    = 8'h00;
    cont_q[0] = 8'h00;
    cont_q[1] = 8'h00;
    cont_n    = 0;
    seq_n     = 0;
  endfunction

  // Take b as the first byte of a sequence; the fit check happens here
  function automatic void open_sequence(logic [7:0] b, ref dest_byte_t res[$]);
    int n;
    if (stopped) return;
    n = utf8_len(b);
    if (written_n + n >= cap_limit()) begin
      stopped = 1'b1;
      return;
    end
    if (n == 1) begin
      res.push_back('{b, 1'b0});
      written_n++;
    end else begin
      lead_q = b;
      seq_n  = n;
      cont_n = 0;
    end
  endfunction

  // Destination bytes caused by one input item
  function automatic void predict_dest_bytes(logic c, logic [7:0] b, ref dest_byte_t res[$]);
    logic [7:0] held [2];
    int         k;
    if (c == CMD_BYTE && seq_n == 0) begin
      open_sequence(b, res);
      return;
    end
    if (c == CMD_BYTE && (b & CONT_MASK) == CONT_CODE) begin
      if (cont_n + 2 >= seq_n) begin
        res.push_back('{lead_q, 1'b0});
        for (int i = 0; i < cont_n; i++) res.push_back('{cont_q[i], 1'b0});
        res.push_back('{b, 1'b0});
        written_n += seq_n;
        drop_sequence();
      end else begin
        cont_q[cont_n] = b;
        cont_n++;
      end
      return;
    end
    // breaking byte or end of string: lead is lost, held bytes start over
    held = cont_q;
    k    = cont_n;
    drop_sequence();
    for (int i = 0; i < k; i++) open_sequence(held[i], res);
    if (c == CMD_BYTE) begin
      open_sequence(b, res);
      return;
    end
    res.push_back('{8'h00, 1'b1});
    written_n = 0;
    stopped   = 1'b0;
  endfunction

  // Compare one output transfer with the oldest expected byte
  function automatic void check_dest_byte();
    dest_byte_t want;
    result_n++;
    if (dest_bytes_q.size() == 0) begin
      $error("unexpected output transfer: out_byte %02h end_of_copy %0b",
             out_byte_o, end_of_copy_o);
      mismatch_n++;
      return;
    end
    want = dest_bytes_q.pop_front();
    if (out_byte_o !== want.value) begin
      $error("out_byte: expected %02h, got %02h", want.value, out_byte_o);
      mismatch_n++;
    end
    if (end_of_copy_o !== want.term) begin
      $error("end_of_copy: expected %0b, got %0b", want.term, end_of_copy_o);
      mismatch_n++;
    end
  endfunction

  // Output side: check, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_dest_byte();
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_left   = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one item, with random idle cycles ahead of it, until transferred
  task automatic drive_item(logic c, logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_n++;
  endtask

  task automatic accept_item(logic c, logic [7:0] b);
    dest_byte_t res [$];
    bit         live;
    live = (c == CMD_END) || !stopped;
    drive_item(c, b);
    predict_dest_bytes(c, b, res);
    foreach (res[i]) dest_bytes_q.push_back(res[i]);
    if (live) live_n++;
    if (live_n == HOLD_AFTER && live) hold_req = 1'b1;
  endtask

  // Drain, then write capacity over APB and read it back
  task automatic write_capacity(logic [CAP_W-1:0] v);
    logic [APB_DW-1:0] word;
    in_valid_i <= 1'b0;
    while (dest_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    word = $urandom;
    word[CAP_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cap_reg = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DW'(v)) begin
      $error("capacity: expected %0d, got %0d", v, prdata);
      mismatch_n++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cap_write_n++;
  endtask

  // Mostly small capacities so that truncation happens often
  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(9))
      0:       return CAP_W'(0);
      1:       return CAP_W'(1);
      2:       return CAP_W'(2);
      3:       return MAX_CAPACITY;
      4:       return CAP_W'(511);
      5:       return CAP_W'(257);
      6, 7:    return CAP_W'($urandom_range(3, 16));
      8:       return CAP_W'($urandom_range(17, 40));
      default: return CAP_W'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return CONT_CODE | (8'($urandom) & ~CONT_MASK);
  endfunction

  // One symbol: ASCII, a full or cut-short sequence, or a raw byte
  task automatic send_symbol();
    int         pick;
    int         n;
    int         k;
    logic [7:0] lead;
    pick = $urandom_range(99);
    n    = $urandom_range(2, 4);
    case (n)
      2:       lead = LEAD2_CODE | (8'($urandom) & ~LEAD2_MASK);
      3:       lead = LEAD3_CODE | (8'($urandom) & ~LEAD3_MASK);
      default: lead = LEAD4_CODE | (8'($urandom) & ~LEAD4_MASK);
    endcase
    if (pick < 30) begin
      accept_item(CMD_BYTE, 8'($urandom_range(1, 127)));
    end else if (pick < 80) begin
      k = (pick < 70) ? n - 1 : $urandom_range(0, n - 2);
      accept_item(CMD_BYTE, lead);
      repeat (k) accept_item(CMD_BYTE, rand_cont());
    end else if (pick < 87) begin
      accept_item(CMD_BYTE, rand_cont());
    end else if (pick < 93) begin
      accept_item(CMD_BYTE, LEAD4_MASK | (8'($urandom) & ~LEAD4_MASK));
    end else begin
      accept_item(CMD_BYTE, 8'($urandom_range(255)));
    end
  endtask

  task automatic send_string();
    int target;
    int first;
    target = ($urandom_range(99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 40);
    first  = item_n;
    while (item_n - first < target) send_symbol();
    accept_item(CMD_END, 8'($urandom));
    string_n++;
  endtask

  initial begin
    dest_byte_t scratch [$];
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].cfg != NO_WRITE) write_capacity(CAP_W'(dir_tab[r].cfg));
      if (dir_tab[r].nres == COMPUTED) begin
        accept_item(dir_tab[r].cmd, dir_tab[r].data);
      end else begin
        drive_item(dir_tab[r].cmd, dir_tab[r].data);
        predict_dest_bytes(dir_tab[r].cmd, dir_tab[r].data, scratch);
        scratch.delete();
        for (int i = 0; i < dir_tab[r].nres; i++) begin
          dest_bytes_q.push_back('{dir_tab[r].res[i],
                                   dir_tab[r].cmd == CMD_END && i == dir_tab[r].nres - 1});
        end
      end
    end

    // Random strings; capacity changes only between strings
    live_n = 0;
    while (item_n < RANDOM_ITEMS) begin
      if (string_n % 3 == 0 && !hold_req && hold_left == 0) write_capacity(pick_capacity());
      quiet = (string_n >= 12 && string_n < 20);
      send_string();
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    while (dest_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);

    $display("Ran %0d strings: %0d input transfers, %0d output transfers,",
             string_n, item_n, result_n);
    $display("%0d capacity settings, one long output hold.", cap_write_n);
    if (mismatch_n == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ utf8_boundary_truncating_copy.f @@
+incdir+design
design/u8btc_pkg.sv
design/utf8_boundary_truncating_copy.sv
bench/testbench.sv
